/* sv/cdq_pkg.sv */
// Shared types and constants for the circular deque block.
package cdq_pkg;

    // Payload and register widths fixed by the interface.
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;
    localparam int STAT_W = 2;

    // Reset value of the capacity register.
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Word index of the capacity register on the configuration port.
    localparam logic REG_CAPACITY = 1'b0;

    typedef logic [DATA_W-1:0] data_t;

    // Request codes carried on req_type.
    typedef enum logic [1:0] {
        REQ_PUSH_REAR  = 2'd0,
        REQ_PUSH_FRONT = 2'd1,
        REQ_POP_REAR   = 2'd2,
        REQ_POP_FRONT  = 2'd3
    } req_t;

    // Completion codes carried on status.
    localparam logic [STAT_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_UNDERFLOW = 2'd2;

    // Command broadcast to every cell of one chain.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_FLUSH,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN,
        CELL_FILL_ABOVE,
        CELL_FILL_BELOW,
        CELL_DROP_TOP,
        CELL_DROP_BOTTOM
    } cell_cmd_t;

endpackage

/* sv/cdq_cell.sv */
// One storage cell of a deque chain: an entry, its valid flag and neighbor moves.
module cdq_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  cdq_pkg::cell_cmd_t cmd,
    input  cdq_pkg::data_t    load_data,
    input  cdq_pkg::data_t    lower_data,
    input  logic              lower_valid,
    input  cdq_pkg::data_t    upper_data,
    input  logic              upper_valid,
    output cdq_pkg::data_t    data,
    output logic              valid
);
    import cdq_pkg::*;

    data_t data_reg;
    data_t data_next;
    logic  valid_reg;
    logic  valid_next;

    // Decide the next entry from the chain command and the neighbors.
    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        unique case (cmd)
            CELL_HOLD:
            begin
                data_next  = data_reg;
            end
            CELL_FLUSH:
            begin
                valid_next = 1'b0;
            end
            CELL_SHIFT_UP:
            begin
                data_next  = lower_data;
                valid_next = lower_valid;
            end
            CELL_SHIFT_DOWN:
            begin
                data_next  = upper_data;
                valid_next = upper_valid;
            end
            CELL_FILL_ABOVE:
            begin
                // The first free cell above the occupied run takes the value.
                if (lower_valid && !valid_reg)
                begin
                    data_next  = load_data;
                    valid_next = 1'b1;
                end
            end
            CELL_FILL_BELOW:
            begin
                // The first free cell below the occupied run takes the value.
                if (upper_valid && !valid_reg)
                begin
                    data_next  = load_data;
                    valid_next = 1'b1;
                end
            end
            CELL_DROP_TOP:
            begin
                // The highest occupied cell gives up its entry.
                if (valid_reg && !upper_valid)
                begin
                    valid_next = 1'b0;
                end
            end
            CELL_DROP_BOTTOM:
            begin
                // The lowest occupied cell gives up its entry.
                if (valid_reg && !lower_valid)
                begin
                    valid_next = 1'b0;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // The valid flag is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // The entry itself needs no reset.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

/* sv/circular_deque.sv */
// Top level of the circular deque: two chains of cells, control and register port.
//
//  channel   signals                                      direction  handshake
//  request   start, busy, req_type, push_value             in         start && !busy
//  result    done, pop_value, status                       out        done, one cycle
//  config    psel, penable, pwrite, paddr, pwdata,         in/out     APB, pready high
//            prdata, pready
//
// Every request is accepted at a clock edge and its result is registered onto the
// result ports for the following cycle, so a new request may follow in every
// cycle. The row of cells, which all move at once, makes this possible.
// Reset empties the deque and sets the capacity to 16; no clearing pass is needed.
// The receiver cannot stall the block: each result is shown for exactly one cycle.
// Writing the capacity register also empties the deque.
module circular_deque
#(
    parameter int DEPTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    req_type,
    input  logic signed [cdq_pkg::DATA_W-1:0] push_value,
    output logic                          done,
    output logic signed [cdq_pkg::DATA_W-1:0] pop_value,
    output logic [cdq_pkg::STAT_W-1:0]    status,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import cdq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Chain F holds the deque with its front at cell 0; chain R holds it
    // with its rear at the top cell. Both always hold the same entries.
    data_t              f_data [DEPTH];
    logic [DEPTH-1:0]   f_valid;
    data_t              r_data [DEPTH];
    logic [DEPTH-1:0]   r_valid;
    cell_cmd_t          f_cmd;
    cell_cmd_t          r_cmd;

    logic [CAP_W-1:0]   cap_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   cap_eff;
    logic               done_reg;
    data_t              pop_value_reg;
    data_t              pop_value_next;
    logic [STAT_W-1:0]  status_reg;
    logic [STAT_W-1:0]  status_next;
    logic               accept;
    logic               cfg_write;
    logic               is_empty;
    logic               is_full;
    req_t               req;

    // The block is never busy, so every request is accepted; its result is registered.
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign req    = req_t'(req_type);

    // Register port: one register, written in the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
    assign prdata    = (paddr[2] == REG_CAPACITY) ? {{(32 - CAP_W){1'b0}}, cap_reg} : 32'd0;

    // Capacity in effect: zero acts as one, anything above the depth as the depth.
    always_comb
    begin
        priority if (cap_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (32'(cap_reg) > 32'(DEPTH))
        begin
            cap_eff = CNT_W'(DEPTH);
        end
        else
        begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == cap_eff);

    // Request decode: chain commands, occupancy and the result.
    always_comb
    begin
        f_cmd          = CELL_HOLD;
        r_cmd          = CELL_HOLD;
        count_next     = count_reg;
        pop_value_next = '0;
        status_next    = STATUS_DONE;
        if (cfg_write)
        begin
            f_cmd      = CELL_FLUSH;
            r_cmd      = CELL_FLUSH;
            count_next = '0;
        end
        else if (accept)
        begin
            unique case (req)
                REQ_PUSH_REAR:
                begin
                    if (is_full)
                    begin
                        status_next = STATUS_OVERFLOW;
                    end
                    else
                    begin
                        f_cmd      = CELL_FILL_ABOVE;
                        r_cmd      = CELL_SHIFT_DOWN;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                REQ_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = STATUS_OVERFLOW;
                    end
                    else
                    begin
                        f_cmd      = CELL_SHIFT_UP;
                        r_cmd      = CELL_FILL_BELOW;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                REQ_POP_REAR:
                begin
                    if (is_empty)
                    begin
                        status_next = STATUS_UNDERFLOW;
                    end
                    else
                    begin
                        pop_value_next = r_data[DEPTH-1];
                        f_cmd          = CELL_DROP_TOP;
                        r_cmd          = CELL_SHIFT_UP;
                        count_next     = count_reg - CNT_W'(1);
                    end
                end
                REQ_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = STATUS_UNDERFLOW;
                    end
                    else
                    begin
                        pop_value_next = f_data[0];
                        f_cmd          = CELL_SHIFT_DOWN;
                        r_cmd          = CELL_DROP_BOTTOM;
                        count_next     = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = STATUS_DONE;
                end
            endcase
        end
    end

    // Row of cells for both chains. At the low end of F and the high end of R
    // the boundary acts as an occupied neighbor that offers the pushed value;
    // at the other ends it acts as an empty neighbor.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            data_t f_lo_d;
            logic  f_lo_v;
            data_t f_up_d;
            logic  f_up_v;
            data_t r_lo_d;
            logic  r_lo_v;
            data_t r_up_d;
            logic  r_up_v;

            if (gi == 0)
            begin : g_low_end
                assign f_lo_d = push_value;
                assign f_lo_v = 1'b1;
                assign r_lo_d = push_value;
                assign r_lo_v = 1'b0;
            end
            else
            begin : g_low_link
                assign f_lo_d = f_data[gi-1];
                assign f_lo_v = f_valid[gi-1];
                assign r_lo_d = r_data[gi-1];
                assign r_lo_v = r_valid[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_high_end
                assign f_up_d = push_value;
                assign f_up_v = 1'b0;
                assign r_up_d = push_value;
                assign r_up_v = 1'b1;
            end
            else
            begin : g_high_link
                assign f_up_d = f_data[gi+1];
                assign f_up_v = f_valid[gi+1];
                assign r_up_d = r_data[gi+1];
                assign r_up_v = r_valid[gi+1];
            end

            cdq_cell u_front_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (f_cmd),
                .load_data   (push_value),
                .lower_data  (f_lo_d),
                .lower_valid (f_lo_v),
                .upper_data  (f_up_d),
                .upper_valid (f_up_v),
                .data        (f_data[gi]),
                .valid       (f_valid[gi])
            );

            cdq_cell u_rear_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (r_cmd),
                .load_data   (push_value),
                .lower_data  (r_lo_d),
                .lower_valid (r_lo_v),
                .upper_data  (r_up_d),
                .upper_valid (r_up_v),
                .data        (r_data[gi]),
                .valid       (r_valid[gi])
            );
        end
    endgenerate

    // Control registers: capacity, occupancy and the result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                cap_reg <= pwdata[CAP_W-1:0];
            end
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        pop_value_reg <= pop_value_next;
        status_reg    <= status_next;
    end

    assign done      = done_reg;
    assign pop_value = pop_value_reg;
    assign status    = status_reg;

`ifndef ASSERT_OFF
    // Occupancy never exceeds the capacity in effect.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= cap_eff)
        else $error("deque occupancy above capacity");

    // Both chains hold exactly as many entries as the occupancy count.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(f_valid) == 32'(count_reg))
        else $error("front chain occupancy mismatch");

    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(r_valid) == 32'(count_reg))
        else $error("rear chain occupancy mismatch");

    // Every accepted transaction gives a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> done)
        else $error("accepted transaction without result");
`endif

endmodule
